[sv/qws_pkg.sv]
// Package for the quoted word splitter: character codes, result kinds,
// quote modes, tally width and the whitespace test.
// No dependencies.
package qws_pkg;

  // Width of the word tally
  localparam int CountBits = 16;

  // Characters with a special meaning
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChEnd       = 8'h00;

  // Result kinds
  localparam logic [1:0] KindChar    = 2'd0;
  localparam logic [1:0] KindWordEnd = 2'd1;
  localparam logic [1:0] KindStrEnd  = 2'd2;

  // Quote modes (code 3 never occurs and acts as no quote)
  localparam logic [1:0] QuoteNone   = 2'd0;
  localparam logic [1:0] QuoteSingle = 2'd1;
  localparam logic [1:0] QuoteDouble = 2'd2;

  // One buffered result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } result_t;

  // Tab, line feed, vertical tab, form feed, carriage return, space
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

[sv/quoted_word_splitter.sv]
// Quoted word splitter top level: input register, tokenizer step and result buffer.
// Depends on qws_pkg.
//
// Takes one character per item and splits the string into words, handling single and
// double quotes and backslash before a double quote; code 0 ends the string and gives the
// word count. An input register accepts a new item every cycle unless the result buffer
// holds it back; the tokenizer step is one pass of combinational logic that loads 0 to 3
// results into a result buffer, which drains one result per cycle while the receiver is
// ready. Items that give at most one result pass at one item per cycle, stalls apart;
// an item with more results holds the next until all leave the buffer's single port.
module quoted_word_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] char_out, [23:8] words_found
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);

  localparam logic [qws_pkg::CountBits-1:0] TallyMax =
    (qws_pkg::CountBits >= 16) ? qws_pkg::CountBits'(16'hFFFF) : '1;

  // Input register
  logic       in_valid_r;
  logic [7:0] in_char_r;

  // Tokenizer state
  logic                          inside_r;
  logic [1:0]                    quote_r;
  logic                          held_r;
  logic [qws_pkg::CountBits-1:0] tally_r;

  // Result buffer
  qws_pkg::result_t              slot_r [0:2];
  logic [qws_pkg::CountBits-1:0] count_r;
  logic [1:0]                    rem_r;
  logic [1:0]                    idx_r;

  // Step outputs
  qws_pkg::result_t              res_nxt [0:2];
  logic [1:0]                    nres_nxt;
  logic                          inside_nxt;
  logic [1:0]                    quote_nxt;
  logic                          held_nxt;
  logic [qws_pkg::CountBits-1:0] tally_nxt;
  logic                          eos_nxt;

  logic buf_load;
  logic out_fire;

  assign out_fire  = out_tvalid && out_tready;
  // Buffer takes the next step when empty or its final result leaves now
  assign buf_load  = in_valid_r && ((rem_r == 2'd0) || ((rem_r == 2'd1) && out_tready));
  assign in_tready = !in_valid_r || buf_load;

  // Tokenizer step for the registered character
  always_comb begin
    logic [7:0] c;
    logic       do_plain;
    logic       do_word;
    logic [7:0] closer;
    c          = in_char_r;
    do_plain   = 1'b0;
    do_word    = 1'b0;
    closer     = qws_pkg::ChDquote;
    nres_nxt   = 2'd0;
    inside_nxt = inside_r;
    quote_nxt  = quote_r;
    held_nxt   = held_r;
    tally_nxt  = tally_r;
    eos_nxt    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res_nxt[i] = '{kind: qws_pkg::KindChar, ch: 8'h00};
    end

    // Resolve a held backslash first
    if (held_r) begin
      held_nxt = 1'b0;
      if (c == qws_pkg::ChDquote) begin
        if (quote_r == qws_pkg::QuoteSingle) begin
          res_nxt[nres_nxt] = '{kind: qws_pkg::KindChar, ch: qws_pkg::ChBackslash};
          nres_nxt = nres_nxt + 2'd1;
        end
        res_nxt[nres_nxt] = '{kind: qws_pkg::KindChar, ch: qws_pkg::ChDquote};
        nres_nxt = nres_nxt + 2'd1;
      end else begin
        res_nxt[nres_nxt] = '{kind: qws_pkg::KindChar, ch: qws_pkg::ChBackslash};
        nres_nxt = nres_nxt + 2'd1;
        do_plain = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    // End of string, word start, or character inside a word
    if (do_plain) begin
      if (c == qws_pkg::ChEnd) begin
        if (inside_r) begin
          res_nxt[nres_nxt] = '{kind: qws_pkg::KindWordEnd, ch: 8'h00};
          nres_nxt = nres_nxt + 2'd1;
        end
        res_nxt[nres_nxt] = '{kind: qws_pkg::KindStrEnd, ch: 8'h00};
        nres_nxt   = nres_nxt + 2'd1;
        eos_nxt    = 1'b1;
        inside_nxt = 1'b0;
        quote_nxt  = qws_pkg::QuoteNone;
        held_nxt   = 1'b0;
        tally_nxt  = '0;
      end else if (!inside_r) begin
        if (!qws_pkg::is_space(c)) begin
          inside_nxt = 1'b1;
          quote_nxt  = qws_pkg::QuoteNone;
          if (tally_r < TallyMax) begin
            tally_nxt = tally_r + qws_pkg::CountBits'(1);
          end
          do_word = 1'b1;
        end
      end else begin
        do_word = 1'b1;
      end
    end

    // Word character handling against the current quote mode
    if (do_word) begin
      if ((quote_nxt == qws_pkg::QuoteSingle) || (quote_nxt == qws_pkg::QuoteDouble)) begin
        closer = (quote_nxt == qws_pkg::QuoteSingle) ? qws_pkg::ChSquote : qws_pkg::ChDquote;
        if (c == qws_pkg::ChBackslash) begin
          held_nxt = 1'b1;
        end else if (c == closer) begin
          quote_nxt = qws_pkg::QuoteNone;
        end else begin
          res_nxt[nres_nxt] = '{kind: qws_pkg::KindChar, ch: c};
          nres_nxt = nres_nxt + 2'd1;
        end
      end else begin
        if (qws_pkg::is_space(c)) begin
          res_nxt[nres_nxt] = '{kind: qws_pkg::KindWordEnd, ch: 8'h00};
          nres_nxt   = nres_nxt + 2'd1;
          inside_nxt = 1'b0;
          quote_nxt  = qws_pkg::QuoteNone;
        end else if (c == qws_pkg::ChBackslash) begin
          held_nxt = 1'b1;
        end else if (c == qws_pkg::ChSquote) begin
          quote_nxt = qws_pkg::QuoteSingle;
        end else if (c == qws_pkg::ChDquote) begin
          quote_nxt = qws_pkg::QuoteDouble;
        end else begin
          res_nxt[nres_nxt] = '{kind: qws_pkg::KindChar, ch: c};
          nres_nxt = nres_nxt + 2'd1;
        end
      end
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
    end
  end

  // Tokenizer state and buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      quote_r  <= qws_pkg::QuoteNone;
      held_r   <= 1'b0;
      tally_r  <= '0;
      rem_r    <= 2'd0;
      idx_r    <= 2'd0;
    end else if (buf_load) begin
      inside_r <= inside_nxt;
      quote_r  <= quote_nxt;
      held_r   <= held_nxt;
      tally_r  <= tally_nxt;
      rem_r    <= nres_nxt;
      idx_r    <= 2'd0;
    end else if (out_fire) begin
      rem_r <= rem_r - 2'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  // Result buffer payload; the count is the tally before end of string clears it
  always_ff @(posedge clk) begin
    if (buf_load) begin
      for (int i = 0; i < 3; i++) begin
        slot_r[i] <= res_nxt[i];
      end
      count_r <= tally_r;
    end
  end

  // Output side
  assign out_tvalid = (rem_r != 2'd0);
  assign out_tuser  = slot_r[idx_r].kind;
  assign out_tlast  = (rem_r == 2'd1);
  assign out_tdata  = {
    (slot_r[idx_r].kind == qws_pkg::KindStrEnd) ? 16'(count_r) : 16'h0000,
    slot_r[idx_r].ch
  };

  // Buffer read position never runs past the three slots
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, idx_r} + {1'b0, rem_r} <= 3'd3))
    else $error("result buffer index out of range");

  // End of string is always the final result of its item
  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == qws_pkg::KindStrEnd)) |-> out_tlast)
    else $error("end of string not marked last");

  // After an end of string the tokenizer is back at its reset state
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_load && eos_nxt) |=>
      ((tally_r == '0) && !inside_r && !held_r && (quote_r == qws_pkg::QuoteNone)))
    else $error("state not cleared after end of string");

endmodule

[bench/qws_checker.sv]
// Result checker for the quoted word splitter: predicts the result items from the
// accepted characters and compares them field by field. Depends on qws_pkg.
`timescale 1ns / 1ps
module qws_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] char_out, [23:8] words_found
  input  logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        out_tlast,  // last
  output int          fail_count,
  output int          tokens_pending,
  output int          tokens_checked
);

  // Cap of the word tally
  localparam logic [15:0] TallyCap =
    (qws_pkg::CountBits >= 16) ? 16'hFFFF : 16'((1 << qws_pkg::CountBits) - 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [15:0] words;
    logic        last;
  } token_t;

  token_t      tokens_due[$];
  token_t      step_toks[3];
  int          step_n;
  token_t      due_tok;

  // Splitter state as the checker tracks it
  logic        in_word;
  logic [1:0]  quote;
  logic        bs_held;
  logic [15:0] tally;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function void add_token(input logic [1:0] kind, input logic [7:0] ch,
                          input logic [15:0] words);
    step_toks[step_n] = '{kind, ch, words, 1'b0};
    step_n++;
  endfunction

  // Character inside a word (quotes, escapes, separators)
  function void word_body(input logic [7:0] c);
    logic [7:0] closer;
    if (quote == qws_pkg::QuoteSingle || quote == qws_pkg::QuoteDouble) begin
      closer = (quote == qws_pkg::QuoteSingle) ? qws_pkg::ChSquote : qws_pkg::ChDquote;
      if (c == qws_pkg::ChBackslash) bs_held = 1'b1;
      else if (c == closer) quote = qws_pkg::QuoteNone;
      else add_token(qws_pkg::KindChar, c, 16'd0);
    end else if (blank_char(c)) begin
      add_token(qws_pkg::KindWordEnd, 8'd0, 16'd0);
      in_word = 1'b0;
      quote = qws_pkg::QuoteNone;
    end else if (c == qws_pkg::ChBackslash) begin
      bs_held = 1'b1;
    end else if (c == qws_pkg::ChSquote) begin
      quote = qws_pkg::QuoteSingle;
    end else if (c == qws_pkg::ChDquote) begin
      quote = qws_pkg::QuoteDouble;
    end else begin
      add_token(qws_pkg::KindChar, c, 16'd0);
    end
  endfunction

  // Character with no pending backslash
  function void plain_body(input logic [7:0] c);
    if (c == qws_pkg::ChEnd) begin
      if (in_word) add_token(qws_pkg::KindWordEnd, 8'd0, 16'd0);
      add_token(qws_pkg::KindStrEnd, 8'd0, tally);
      in_word = 1'b0;
      quote = qws_pkg::QuoteNone;
      bs_held = 1'b0;
      tally = 16'd0;
    end else if (!in_word) begin
      if (!blank_char(c)) begin
        in_word = 1'b1;
        quote = qws_pkg::QuoteNone;
        if (tally < TallyCap) tally++;
        word_body(c);
      end
    end else begin
      word_body(c);
    end
  endfunction

  // One accepted character: queue the result items it causes
  function void split_step(input logic [7:0] c);
    int i;
    step_n = 0;
    if (bs_held) begin
      bs_held = 1'b0;
      if (c == qws_pkg::ChDquote) begin
        if (quote == qws_pkg::QuoteSingle)
          add_token(qws_pkg::KindChar, qws_pkg::ChBackslash, 16'd0);
        add_token(qws_pkg::KindChar, qws_pkg::ChDquote, 16'd0);
      end else begin
        add_token(qws_pkg::KindChar, qws_pkg::ChBackslash, 16'd0);
        plain_body(c);
      end
    end else begin
      plain_body(c);
    end
    for (i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_toks[i].last = 1'b1;
      tokens_due.push_back(step_toks[i]);
    end
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_word = 1'b0;
      quote = qws_pkg::QuoteNone;
      bs_held = 1'b0;
      tally = 16'd0;
      tokens_due.delete();
      fail_count = 0;
      tokens_checked = 0;
    end else begin
      if (in_tvalid && in_tready) split_step(in_tdata);
      if (out_tvalid && out_tready) begin
        tokens_checked++;
        if (tokens_due.size() == 0) begin
          $error("result item with none expected: kind %0d char_out %0d words_found %0d",
                 out_tuser, out_tdata[7:0], out_tdata[23:8]);
          fail_count++;
        end else begin
          due_tok = tokens_due.pop_front();
          if (out_tuser !== due_tok.kind) begin
            $error("kind: expected %0d, got %0d", due_tok.kind, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] !== due_tok.ch) begin
            $error("char_out: expected %0d, got %0d", due_tok.ch, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[23:8] !== due_tok.words) begin
            $error("words_found: expected %0d, got %0d", due_tok.words, out_tdata[23:8]);
            fail_count++;
          end
          if (out_tlast !== due_tok.last) begin
            $error("last: expected %0d, got %0d", due_tok.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    tokens_pending = tokens_due.size();
  end

endmodule

[bench/tb_quoted_word_splitter.sv]
// Testbench top for the quoted word splitter: clock, reset, character stimulus,
// output back-pressure, watchdog and verdict. Depends on qws_pkg and qws_checker.
`timescale 1ns / 1ps
module tb_quoted_word_splitter;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 95;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [7:0] char_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] char_out, [23:8] words_found
  logic [1:0]  out_tuser;          // [1:0] kind
  logic        out_tlast;          // last

  int fail_count;
  int tokens_pending;
  int tokens_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  // Directed strings: empty quoted words, unclosed quote with escaped dquote,
  // backslash runs ending at end of string, whitespace bounds, escape outside quotes
  logic [7:0] directed_chars[24] = '{
    qws_pkg::ChSquote, qws_pkg::ChSquote, 8'h20, qws_pkg::ChDquote, qws_pkg::ChDquote,
    qws_pkg::ChEnd,
    qws_pkg::ChSquote, 8'h78, qws_pkg::ChBackslash, qws_pkg::ChDquote, qws_pkg::ChEnd,
    qws_pkg::ChBackslash, qws_pkg::ChBackslash, qws_pkg::ChBackslash, qws_pkg::ChEnd,
    8'hFF, 8'h09, 8'h08, 8'h0D, 8'h0E, qws_pkg::ChEnd,
    qws_pkg::ChBackslash, qws_pkg::ChDquote, qws_pkg::ChEnd
  };

  always #2 clk = ~clk;

  quoted_word_splitter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  qws_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .tokens_pending (tokens_pending),
    .tokens_checked (tokens_checked)
  );

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one character, idling at random first
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  // Mostly word text, separators, quotes and backslashes; now and then any nonzero code
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 45) return ($urandom_range(0, 1) == 1) ? 8'h20 : 8'($urandom_range(9, 13));
    if (r < 57) return qws_pkg::ChSquote;
    if (r < 69) return qws_pkg::ChDquote;
    if (r < 82) return qws_pkg::ChBackslash;
    return 8'($urandom_range(1, 255));
  endfunction

  // Random string, always closed by the end code
  task automatic send_random_string();
    int len;
    len = $urandom_range(0, 24);
    repeat (len) send_char(pick_char());
    send_char(qws_pkg::ChEnd);
    strings_sent++;
  endtask

  task automatic run_phase(input int idle, input int stall, input int items);
    int start;
    start = chars_sent;
    idle_pct = idle;
    stall_pct = stall;
    while (chars_sent - start < items) send_random_string();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings
    foreach (directed_chars[i]) begin
      send_char(directed_chars[i]);
      if (directed_chars[i] == qws_pkg::ChEnd) strings_sent++;
    end

    // Random strings under each idle and stall mix
    run_phase(0, 0, PhaseItems);
    run_phase(46, 0, PhaseItems);
    run_phase(0, 46, PhaseItems);
    run_phase(9, 9, PhaseItems);

    // Long receiver hold-off while characters keep coming
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    run_phase(0, 0, 40);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tokens_pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters in %0d strings with idling, stalls and a long hold-off",
             chars_sent, strings_sent);
    $display("Compared %0d result items against the predicted word stream",
             tokens_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/qws_pkg.sv
sv/quoted_word_splitter.sv
bench/qws_checker.sv
bench/tb_quoted_word_splitter.sv
